// ----- design/bile_pkg.sv -----
// bile_pkg: shared types and constants for the bounded integer list engine
// holds action codes, controller states and the command/status structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bile_pkg;

	localparam int CAPACITY_DEF    = 16;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int ACTION_W        = 3;
	localparam int PORT_VALUE_W    = 32;
	localparam int PORT_COUNT_W    = 5;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_INSERT     = 3'd2,
		ACT_POP_FRONT  = 3'd3,
		ACT_POP_BACK   = 3'd4,
		ACT_REMOVE     = 3'd5,
		ACT_CONTAINS   = 3'd6
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN_RD,
		ST_SCAN_EX,
		ST_SHR_RD,
		ST_SHR_WR,
		ST_PUT,
		ST_TAKE_RD,
		ST_TAKE_EX,
		ST_SHL_RD,
		ST_SHL_WR,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_IDX_M1,
		RD_IDX_P1
	} rd_sel_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_CNT,
		IDX_CNT_M1,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	typedef enum logic [1:0] {
		POS_HOLD,
		POS_ZERO,
		POS_CNT,
		POS_IDX
	} pos_op_t;

	typedef struct packed {
		logic    load;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		logic    wr_put;
		idx_op_t idx_op;
		pos_op_t pos_op;
		logic    set_ok;
		logic    take;
		logic    cnt_inc;
		logic    cnt_dec;
	} ctrl_t;

	typedef struct packed {
		action_t act;
		logic    empty;
		logic    full;
		logic    hit;
		logic    last;
		logic    at_pos;
	} stat_t;

endpackage
`default_nettype wire

// ----- design/bile_ctrl.sv -----
// bile_ctrl: controller state machine of the list engine
// walks scan, shift, put and take steps; depends on bile_pkg
`timescale 1ns / 1ps
`default_nettype none
module bile_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  bile_pkg::stat_t      st,
	output bile_pkg::ctrl_t      cmd,
	output logic                 busy,
	output logic                 done
);

	bile_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bile_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		done    = 1'b0;
		busy    = (state_q != bile_pkg::ST_IDLE);
		case (state_q)
			bile_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = bile_pkg::ST_DECODE;
				end
			end
			bile_pkg::ST_DECODE: begin
				case (st.act)
					bile_pkg::ACT_PUSH_FRONT, bile_pkg::ACT_PUSH_BACK,
					bile_pkg::ACT_INSERT: begin
						if (st.full) begin
							state_d = bile_pkg::ST_DONE;
						end else if (st.act == bile_pkg::ACT_PUSH_BACK) begin
							cmd.pos_op = bile_pkg::POS_CNT;
							state_d    = bile_pkg::ST_PUT;
						end else if (st.act == bile_pkg::ACT_PUSH_FRONT || st.empty) begin
							cmd.pos_op = bile_pkg::POS_ZERO;
							cmd.idx_op = bile_pkg::IDX_CNT;
							state_d    = bile_pkg::ST_SHR_RD;
						end else begin
							cmd.idx_op = bile_pkg::IDX_ZERO;
							state_d    = bile_pkg::ST_SCAN_RD;
						end
					end
					bile_pkg::ACT_POP_FRONT: begin
						if (st.empty) begin
							state_d = bile_pkg::ST_DONE;
						end else begin
							cmd.idx_op = bile_pkg::IDX_ZERO;
							state_d    = bile_pkg::ST_TAKE_RD;
						end
					end
					bile_pkg::ACT_POP_BACK: begin
						if (st.empty) begin
							state_d = bile_pkg::ST_DONE;
						end else begin
							cmd.idx_op = bile_pkg::IDX_CNT_M1;
							state_d    = bile_pkg::ST_TAKE_RD;
						end
					end
					bile_pkg::ACT_REMOVE, bile_pkg::ACT_CONTAINS: begin
						if (st.empty) begin
							state_d = bile_pkg::ST_DONE;
						end else begin
							cmd.idx_op = bile_pkg::IDX_ZERO;
							state_d    = bile_pkg::ST_SCAN_RD;
						end
					end
					default: begin
						state_d = bile_pkg::ST_DONE;
					end
				endcase
			end
			bile_pkg::ST_SCAN_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = bile_pkg::RD_IDX;
				state_d    = bile_pkg::ST_SCAN_EX;
			end
			bile_pkg::ST_SCAN_EX: begin
				if (st.hit) begin
					if (st.act == bile_pkg::ACT_INSERT) begin
						cmd.pos_op = bile_pkg::POS_IDX;
						cmd.idx_op = bile_pkg::IDX_CNT;
						state_d    = bile_pkg::ST_SHR_RD;
					end else if (st.act == bile_pkg::ACT_CONTAINS) begin
						cmd.set_ok = 1'b1;
						state_d    = bile_pkg::ST_DONE;
					end else begin
						cmd.set_ok = 1'b1;
						cmd.take   = 1'b1;
						state_d    = bile_pkg::ST_SHL_RD;
					end
				end else if (st.last) begin
					if (st.act == bile_pkg::ACT_INSERT) begin
						cmd.pos_op = bile_pkg::POS_CNT;
						state_d    = bile_pkg::ST_PUT;
					end else begin
						state_d = bile_pkg::ST_DONE;
					end
				end else begin
					cmd.idx_op = bile_pkg::IDX_INC;
					state_d    = bile_pkg::ST_SCAN_RD;
				end
			end
			bile_pkg::ST_SHR_RD: begin
				if (st.at_pos) begin
					state_d = bile_pkg::ST_PUT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = bile_pkg::RD_IDX_M1;
					state_d    = bile_pkg::ST_SHR_WR;
				end
			end
			bile_pkg::ST_SHR_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.idx_op = bile_pkg::IDX_DEC;
				state_d    = bile_pkg::ST_SHR_RD;
			end
			bile_pkg::ST_PUT: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_put  = 1'b1;
				cmd.cnt_inc = 1'b1;
				cmd.set_ok  = 1'b1;
				state_d     = bile_pkg::ST_DONE;
			end
			bile_pkg::ST_TAKE_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = bile_pkg::RD_IDX;
				state_d    = bile_pkg::ST_TAKE_EX;
			end
			bile_pkg::ST_TAKE_EX: begin
				cmd.set_ok = 1'b1;
				cmd.take   = 1'b1;
				state_d    = bile_pkg::ST_SHL_RD;
			end
			bile_pkg::ST_SHL_RD: begin
				if (st.last) begin
					cmd.cnt_dec = 1'b1;
					state_d     = bile_pkg::ST_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = bile_pkg::RD_IDX_P1;
					state_d    = bile_pkg::ST_SHL_WR;
				end
			end
			bile_pkg::ST_SHL_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.idx_op = bile_pkg::IDX_INC;
				state_d    = bile_pkg::ST_SHL_RD;
			end
			bile_pkg::ST_DONE: begin
				done    = 1'b1;
				state_d = bile_pkg::ST_IDLE;
			end
			default: begin
				state_d = bile_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- design/bile_dpath.sv -----
// bile_dpath: datapath of the list engine
// entry memory, count, walk index, compare and result registers; depends on bile_pkg
`timescale 1ns / 1ps
`default_nettype none
module bile_dpath #(
	parameter int CAPACITY    = bile_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = bile_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic [bile_pkg::ACTION_W-1:0]          action,
	input  wire logic signed [bile_pkg::PORT_VALUE_W-1:0] value,
	input  bile_pkg::ctrl_t                             cmd,
	output bile_pkg::stat_t                             st,
	output logic                                        ok,
	output logic signed [bile_pkg::PORT_VALUE_W-1:0]    taken_value,
	output logic [bile_pkg::PORT_COUNT_W-1:0]           count,
	output logic                                        empty_res
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int PW = bile_pkg::PORT_VALUE_W;
	localparam int NW = bile_pkg::PORT_COUNT_W;

	logic [VALUE_WIDTH-1:0] mem [CAPACITY];

	logic [CW-1:0]                cnt_q;
	logic [CW-1:0]                idx_q;
	logic [CW-1:0]                pos_q;
	logic signed [VALUE_WIDTH-1:0] val_q;
	logic signed [VALUE_WIDTH-1:0] rdata_q;
	logic signed [VALUE_WIDTH-1:0] taken_q;
	logic                         ok_q;
	bile_pkg::action_t            act_q;

	logic [CW-1:0]                idx_m1;
	logic [CW-1:0]                idx_p1;
	logic [CW-1:0]                rd_idx;
	logic [AW-1:0]                rd_addr;
	logic [AW-1:0]                wr_addr;
	logic [VALUE_WIDTH-1:0]       wr_data;
	logic [VALUE_WIDTH+PW-1:0]    value_ext;
	logic [VALUE_WIDTH+PW-1:0]    taken_ext;
	logic [CW+NW-1:0]             cnt_ext;

	assign idx_m1 = idx_q - CW'(1);
	assign idx_p1 = idx_q + CW'(1);

	// input value brought to the stored width, sign-extended when wider
	assign value_ext = {{VALUE_WIDTH{value[PW-1]}}, value};

	always_comb begin
		case (cmd.rd_sel)
			bile_pkg::RD_IDX:    rd_idx = idx_q;
			bile_pkg::RD_IDX_M1: rd_idx = idx_m1;
			bile_pkg::RD_IDX_P1: rd_idx = idx_p1;
			default:             rd_idx = idx_q;
		endcase
	end

	assign rd_addr = rd_idx[AW-1:0];
	assign wr_addr = cmd.wr_put ? pos_q[AW-1:0] : idx_q[AW-1:0];
	assign wr_data = cmd.wr_put ? val_q : rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= bile_pkg::action_t'(action);
			val_q   <= value_ext[VALUE_WIDTH-1:0];
			ok_q    <= 1'b0;
			taken_q <= '0;
		end else begin
			if (cmd.set_ok) begin
				ok_q <= 1'b1;
			end
			if (cmd.take) begin
				taken_q <= rdata_q;
			end
		end
		case (cmd.idx_op)
			bile_pkg::IDX_HOLD:   idx_q <= idx_q;
			bile_pkg::IDX_ZERO:   idx_q <= '0;
			bile_pkg::IDX_CNT:    idx_q <= cnt_q;
			bile_pkg::IDX_CNT_M1: idx_q <= cnt_q - CW'(1);
			bile_pkg::IDX_INC:    idx_q <= idx_p1;
			bile_pkg::IDX_DEC:    idx_q <= idx_m1;
			default:              idx_q <= idx_q;
		endcase
		case (cmd.pos_op)
			bile_pkg::POS_HOLD: pos_q <= pos_q;
			bile_pkg::POS_ZERO: pos_q <= '0;
			bile_pkg::POS_CNT:  pos_q <= cnt_q;
			bile_pkg::POS_IDX:  pos_q <= idx_q;
			default:            pos_q <= pos_q;
		endcase
	end

	// insert stops at the head if it is not below the value, later at the first greater entry
	always_comb begin
		st.act    = act_q;
		st.empty  = (cnt_q == '0);
		st.full   = (cnt_q == CW'(CAPACITY));
		st.last   = (idx_p1 == cnt_q);
		st.at_pos = (idx_q == pos_q);
		if (act_q == bile_pkg::ACT_INSERT) begin
			st.hit = (idx_q == '0) ? (rdata_q >= val_q) : (rdata_q > val_q);
		end else begin
			st.hit = (rdata_q == val_q);
		end
	end

	assign taken_ext   = {{PW{taken_q[VALUE_WIDTH-1]}}, taken_q};
	assign cnt_ext     = {{NW{1'b0}}, cnt_q};
	assign ok          = ok_q;
	assign taken_value = taken_ext[PW-1:0];
	assign count       = cnt_ext[NW-1:0];
	assign empty_res   = (cnt_q == '0);

endmodule
`default_nettype wire

// ----- design/bounded_integer_list_engine.sv -----
// List of up to CAPACITY signed values kept in a one-port entry memory,
// walked one entry at a time. A request is taken when start is high and busy is
// low; its result appears for exactly one cycle with done high and cannot be held
// off, so the receiver must take it then. The shortest requests are a refused push
// or insert, an unused action code, or a pop, remove or contains on an empty list;
// the longest is an ordered insert that lands ahead of the back on a list one short
// of full. Push back on a free list writes at the back without a walk. An ordered
// insert, remove, contains, pop front or push front walks the stored entries, each
// entry a memory read, then a compare or a write back. busy falls in the cycle after
// done. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module bounded_integer_list_engine #(
	parameter int CAPACITY    = bile_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = bile_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     start,
	output logic                                          busy,
	input  wire logic [bile_pkg::ACTION_W-1:0]            action,
	input  wire logic signed [bile_pkg::PORT_VALUE_W-1:0] value,
	output logic                                          done,
	output logic                                          ok,
	output logic signed [bile_pkg::PORT_VALUE_W-1:0]      taken_value,
	output logic [bile_pkg::PORT_COUNT_W-1:0]             count,
	output logic                                          empty_res
);

	bile_pkg::ctrl_t cmd;
	bile_pkg::stat_t st;

	bile_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	bile_dpath #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.action      (action),
		.value       (value),
		.cmd         (cmd),
		.st          (st),
		.ok          (ok),
		.taken_value (taken_value),
		.count       (count),
		.empty_res   (empty_res)
	);

	// one result per request, then back to idle
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("done held longer than one cycle");

	// accepted request keeps the engine busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted without going busy");

	// a full list never grows
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(st.full && cmd.cnt_inc))
		else $error("count increment on full list");

	// an empty list never shrinks
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(st.empty && cmd.cnt_dec))
		else $error("count decrement on empty list");

endmodule
`default_nettype wire
